[hdl/crt_pkg.sv]
// Shared types and constants for the custody record table.
package crt_pkg;

    // Widths fixed by the transaction fields
    localparam int unsigned NODE_BITS = 16;
    localparam int unsigned TIME_BITS = 32;
    localparam int unsigned KEY_BITS  = 64;
    localparam int unsigned SIZE_BITS = 32;

    // Defaults for the top-level parameters
    localparam int unsigned                CRT_MAX_ENTRIES    = 64;
    localparam logic [TIME_BITS-1:0]       CRT_FALLBACK_TICKS = 32'd3600;

    // Command codes
    localparam logic [2:0] CMD_ACCEPT   = 3'd0;
    localparam logic [2:0] CMD_TRANSFER = 3'd1;
    localparam logic [2:0] CMD_RELEASE  = 3'd2;
    localparam logic [2:0] CMD_TIMEOUT  = 3'd3;
    localparam logic [2:0] CMD_GET      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NO   = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Command transaction
    typedef struct packed {
        logic [2:0]           cmd;
        logic [KEY_BITS-1:0]  bundle_key;
        logic [NODE_BITS-1:0] node_id;
        logic [TIME_BITS-1:0] now_time;
        logic                 bundle_alive;
        logic [SIZE_BITS-1:0] buffer_free;
        logic [SIZE_BITS-1:0] bundle_size;
        logic                 policy_reject;
    } t_cmd_in;

    // Result transaction
    typedef struct packed {
        logic [1:0]           status;
        logic [NODE_BITS-1:0] record_custodian;
        logic [TIME_BITS-1:0] record_accept_time;
        logic [TIME_BITS-1:0] record_deadline;
    } t_res_out;

    // One stored custody record
    typedef struct packed {
        logic [KEY_BITS-1:0]  bundle;
        logic [NODE_BITS-1:0] custodian;
        logic [TIME_BITS-1:0] accept_time;
        logic [TIME_BITS-1:0] deadline;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SWAP,
        S_DONE
    } t_state;

endpackage

[hdl/crt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module crt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/custody_record_table.sv]
// Custody record table: top level with command sequencer and record memory.
//
// The block holds up to MAX_ENTRIES custody records in one synchronous RAM,
// kept packed below a fill count. Each command transaction scans the live
// records one per cycle through the RAM read port for the first matching
// bundle id, then acts on the hit: accept check, transfer (update or append),
// release (swap-remove with the last record), timeout query or get. The
// scan, one record per cycle, dominates each command; release adds a swap
// step, while refused accept checks and unknown codes skip the scan and
// go straight to the result. One command is in flight at a
// time; a new one is taken while the previous result waits in the output
// register. No clearing pass follows reset; the table starts empty.
module custody_record_table
    import crt_pkg::*;
#(
    parameter int unsigned          MAX_ENTRIES    = CRT_MAX_ENTRIES,
    parameter logic [TIME_BITS-1:0] FALLBACK_TICKS = CRT_FALLBACK_TICKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_cmd_in              i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_res_out             o_out_data,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [TIME_BITS-1:0] i_cfg_wdata
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EW = $bits(t_entry);

    t_state               r_state, n_state;
    t_cmd_in              r_req, n_req;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic                 r_found, n_found;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    t_entry               r_hit, n_hit;
    logic [CW-1:0]        r_fill, n_fill;
    t_res_out             r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_res_out             r_out, n_out;
    logic [TIME_BITS-1:0] r_timeout;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic [AW-1:0]        ram_raddr;
    t_entry               ram_rdata;
    logic [EW-1:0]        ram_rbits;

    logic                 in_acc;
    logic                 out_free;
    logic                 key_match;
    logic [TIME_BITS-1:0] tmo;
    logic [TIME_BITS:0]   dl_sum;
    logic [TIME_BITS-1:0] deadline;

    // Record storage
    crt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_entry'(ram_rbits);

    assign in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    // Deadline: now + timeout, saturating at the largest time value
    assign tmo      = (r_timeout != '0) ? r_timeout : FALLBACK_TICKS;
    assign dl_sum   = {1'b0, r_req.now_time} + {1'b0, tmo};
    assign deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

    // Scan compare; accept check also needs the same custodian
    assign key_match = r_pend && (ram_rdata.bundle == r_req.bundle_key) &&
                       ((r_req.cmd != CMD_ACCEPT) ||
                        (ram_rdata.custodian == r_req.node_id));

    // Sequencer: next state, memory accesses, result
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit       = r_hit;
        n_fill      = r_fill;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_res   = '{status: ST_NO, default: '0};
                    if (i_in_data.cmd > CMD_GET) begin
                        n_state = S_DONE;
                    end else if ((i_in_data.cmd == CMD_ACCEPT) &&
                                 !(i_in_data.bundle_alive && !i_in_data.policy_reject &&
                                   (i_in_data.buffer_free >= i_in_data.bundle_size))) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // One read issued and one compare made per cycle
            S_SCAN: begin
                if (key_match) begin
                    n_found   = 1'b1;
                    n_hit     = ram_rdata;
                    n_hit_idx = AW'(r_idx - CW'(1));
                    n_pend    = 1'b0;
                    n_state   = S_ACT;
                end else if (r_idx < r_fill) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_ACT;
                    end
                end
            end

            S_ACT: begin
                n_res   = '{status: ST_NO, default: '0};
                n_state = S_DONE;
                unique case (r_req.cmd)
                    CMD_ACCEPT: begin
                        n_res.status = r_found ? ST_NO : ST_OK;
                    end
                    CMD_TRANSFER: begin
                        if (r_found || (r_fill != CW'(MAX_ENTRIES))) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_found ? r_hit_idx : r_fill[AW-1:0];
                            ram_wdata = '{bundle:      r_req.bundle_key,
                                          custodian:   r_req.node_id,
                                          accept_time: r_req.now_time,
                                          deadline:    deadline};
                            n_res = '{status:             ST_OK,
                                      record_custodian:   r_req.node_id,
                                      record_accept_time: r_req.now_time,
                                      record_deadline:    deadline};
                            if (!r_found) begin
                                n_fill = r_fill + CW'(1);
                            end
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    CMD_RELEASE: begin
                        if (r_found) begin
                            n_res = '{status:             ST_OK,
                                      record_custodian:   r_hit.custodian,
                                      record_accept_time: r_hit.accept_time,
                                      record_deadline:    r_hit.deadline};
                            // fetch the last record to fill the hole
                            ram_raddr = AW'(r_fill - CW'(1));
                            n_state   = S_SWAP;
                        end
                    end
                    CMD_TIMEOUT: begin
                        if (r_found) begin
                            n_res = '{status: (r_req.now_time >= r_hit.deadline) ?
                                              ST_OK : ST_NO,
                                      record_custodian:   r_hit.custodian,
                                      record_accept_time: r_hit.accept_time,
                                      record_deadline:    r_hit.deadline};
                        end
                    end
                    CMD_GET: begin
                        if (r_found) begin
                            n_res = '{status:             ST_OK,
                                      record_custodian:   r_hit.custodian,
                                      record_accept_time: r_hit.accept_time,
                                      record_deadline:    r_hit.deadline};
                        end
                    end
                    default: begin
                        n_res.status = ST_NO;
                    end
                endcase
            end

            // Move the last record into the released slot
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = ram_rdata;
                n_fill    = r_fill - CW'(1);
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_timeout   <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_idx       <= n_idx;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_hit_idx <= n_hit_idx;
        r_hit     <= n_hit;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_ENTRIES))
        else $error("fill count beyond table depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_ACT) || (r_state == S_SWAP)))
        else $error("record write outside action states");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ((r_fill == $past(r_fill) + CW'(1)) || (r_fill == $past(r_fill) - CW'(1))))
        else $error("fill count moved by more than one");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("undefined status code");

    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted command dropped");

endmodule

[tb/sv/custody_record_table_tb.sv]
// Self-checking testbench for the custody record table: directed rows, then random phases.
`timescale 1ns / 1ps

module custody_record_table_tb;
    import crt_pkg::*;

    // Command codes the block does not define; they must come back refused
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    localparam int KEY_POOL      = 72;     // a little more than the table holds
    localparam int SETTLE_CYCLES = 80;     // a full scan plus the command overhead
    localparam int CYCLE_LIMIT   = 400000;
    localparam int N_DIRECTED    = 25;
    localparam int N_PHASES      = 5;

    localparam logic [KEY_BITS-1:0] KEY_LO  = '0;
    localparam logic [KEY_BITS-1:0] KEY_HI  = '1;
    localparam logic [KEY_BITS-1:0] KEY_MID = 64'h0123_4567_89AB_CDEF;
    localparam logic [TIME_BITS-1:0] T_MAX  = '1;
    localparam logic [SIZE_BITS-1:0] SZ_MAX = '1;

    // One directed row: stimulus plus, where obvious, the result typed in
    typedef struct packed {
        t_cmd_in  stim;
        logic     has_want;
        t_res_out want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_cmd_in              i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_res_out             o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [TIME_BITS-1:0] i_cfg_wdata = '0;

    // Mirror of the block's table and register
    t_entry               custody_tab [CRT_MAX_ENTRIES];
    int                   live_records = 0;
    logic [TIME_BITS-1:0] timeout_reg = '0;

    // Results still owed by the block, oldest first
    t_res_out             expected_results [$];

    // Stimulus state
    logic [KEY_BITS-1:0]  key_pool [KEY_POOL];
    int                   fill_cursor = 0;
    logic [TIME_BITS-1:0] sim_clock = '0;
    bit                   idle_enable = 1'b1;
    int                   ready_hold = 0;

    // Statistics
    int                   cmd_seen [8];
    int                   full_refusals = 0;
    int                   saturated_deadlines = 0;
    int                   peak_fill = 0;
    int                   checked_results = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;

    custody_record_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Work out the result of one command and update the mirrored table
    function automatic t_res_out custody_predict(input t_cmd_in c);
        t_res_out             r;
        int                   hit;
        int                   last;
        bit                   ok;
        logic [TIME_BITS-1:0] span;
        logic [TIME_BITS:0]   sum;
        r = '0;
        r.status = ST_NO;
        hit = -1;
        for (int i = live_records - 1; i >= 0; i--) begin
            if (custody_tab[i].bundle == c.bundle_key) hit = i;
        end
        cmd_seen[c.cmd]++;
        case (c.cmd)
            CMD_ACCEPT: begin
                ok = c.bundle_alive && (c.buffer_free >= c.bundle_size) && !c.policy_reject;
                for (int i = 0; i < live_records; i++) begin
                    if (custody_tab[i].bundle == c.bundle_key &&
                        custody_tab[i].custodian == c.node_id) ok = 1'b0;
                end
                if (ok) r.status = ST_OK;
            end
            CMD_TRANSFER: begin
                if (hit < 0 && live_records >= CRT_MAX_ENTRIES) begin
                    r.status = ST_FULL;
                    full_refusals++;
                end else begin
                    if (hit < 0) begin
                        hit = live_records;
                        live_records++;
                        custody_tab[hit].bundle = c.bundle_key;
                        if (live_records > peak_fill) peak_fill = live_records;
                    end
                    // deadline saturates at the largest time value
                    span = (timeout_reg == '0) ? CRT_FALLBACK_TICKS : timeout_reg;
                    sum = {1'b0, c.now_time} + {1'b0, span};
                    if (sum[TIME_BITS]) saturated_deadlines++;
                    custody_tab[hit].custodian   = c.node_id;
                    custody_tab[hit].accept_time = c.now_time;
                    custody_tab[hit].deadline    = sum[TIME_BITS] ? T_MAX : sum[TIME_BITS-1:0];
                    r.status = ST_OK;
                end
            end
            CMD_RELEASE, CMD_TIMEOUT, CMD_GET: begin
                if (hit >= 0) begin
                    r.status = ST_OK;
                    if (c.cmd == CMD_TIMEOUT && c.now_time < custody_tab[hit].deadline)
                        r.status = ST_NO;
                end
            end
            default: ;
        endcase
        if (hit >= 0 && r.status != ST_FULL && c.cmd != CMD_ACCEPT &&
            c.cmd <= CMD_GET) begin
            r.record_custodian   = custody_tab[hit].custodian;
            r.record_accept_time = custody_tab[hit].accept_time;
            r.record_deadline    = custody_tab[hit].deadline;
        end
        // release moves the last record into the freed slot
        if (c.cmd == CMD_RELEASE && hit >= 0) begin
            last = live_records - 1;
            custody_tab[hit] = custody_tab[last];
            live_records = last;
        end
        return r;
    endfunction

    function automatic t_cmd_in mk_cmd(input logic [2:0] cmd, input logic [KEY_BITS-1:0] key,
                                       input logic [NODE_BITS-1:0] node,
                                       input logic [TIME_BITS-1:0] now, input logic alive,
                                       input logic [SIZE_BITS-1:0] free_bytes,
                                       input logic [SIZE_BITS-1:0] size_bytes,
                                       input logic reject);
        t_cmd_in c;
        c.cmd           = cmd;
        c.bundle_key    = key;
        c.node_id       = node;
        c.now_time      = now;
        c.bundle_alive  = alive;
        c.buffer_free   = free_bytes;
        c.bundle_size   = size_bytes;
        c.policy_reject = reject;
        return c;
    endfunction

    function automatic t_res_out mk_res(input logic [1:0] st, input logic [NODE_BITS-1:0] cust,
                                        input logic [TIME_BITS-1:0] acc,
                                        input logic [TIME_BITS-1:0] dl);
        t_res_out r;
        r.status             = st;
        r.record_custodian   = cust;
        r.record_accept_time = acc;
        r.record_deadline    = dl;
        return r;
    endfunction

    // Random command; keys lean toward records that are held so hits are common
    function automatic t_cmd_in next_random_cmd(input bit fill_mode);
        t_cmd_in c;
        int      r;
        int      held;
        c = '0;
        held = -1;
        r = $urandom_range(0, 99);
        if (fill_mode) begin
            if (r < 80)      c.cmd = CMD_TRANSFER;
            else if (r < 83) c.cmd = CMD_RELEASE;
            else if (r < 88) c.cmd = CMD_ACCEPT;
            else if (r < 93) c.cmd = CMD_TIMEOUT;
            else if (r < 98) c.cmd = CMD_GET;
            else             c.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end else begin
            if (r < 20)      c.cmd = CMD_ACCEPT;
            else if (r < 50) c.cmd = CMD_TRANSFER;
            else if (r < 65) c.cmd = CMD_RELEASE;
            else if (r < 82) c.cmd = CMD_TIMEOUT;
            else if (r < 97) c.cmd = CMD_GET;
            else             c.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end

        // bundle id
        r = $urandom_range(0, 99);
        if (fill_mode && c.cmd == CMD_TRANSFER && r < 75) begin
            c.bundle_key = key_pool[fill_cursor % KEY_POOL];
            fill_cursor++;
        end else if (r < 50 && live_records > 0) begin
            held = $urandom_range(0, live_records - 1);
            c.bundle_key = custody_tab[held].bundle;
        end else if (r < 85) begin
            c.bundle_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        end else begin
            c.bundle_key = {$urandom, $urandom};
        end

        // custodian: reuse the holder now and then to hit the same-custodian refusal
        r = $urandom_range(0, 99);
        if (held >= 0 && r < 40) c.node_id = custody_tab[held].custodian;
        else if (r < 50)         c.node_id = '0;
        else if (r < 60)         c.node_id = '1;
        else                     c.node_id = 16'($urandom);

        // time mostly walks forward, with jumps and the top value mixed in
        sim_clock += 32'($urandom_range(0, 400));
        r = $urandom_range(0, 99);
        if (r < 8)       c.now_time = T_MAX;
        else if (r < 18) c.now_time = $urandom;
        else             c.now_time = sim_clock;

        c.bundle_alive = ($urandom_range(0, 99) < 85);
        r = $urandom_range(0, 99);
        if (r < 25) begin
            c.buffer_free = $urandom;
            c.bundle_size = c.buffer_free;
        end else if (r < 50) begin
            c.buffer_free = $urandom_range(0, 1000);
            c.bundle_size = $urandom_range(0, 1000);
        end else begin
            c.buffer_free = $urandom;
            c.bundle_size = $urandom;
        end
        c.policy_reject = ($urandom_range(0, 99) < 15);
        return c;
    endfunction

    // Offer one command transaction; called and returns at a falling edge
    task automatic send_cmd(input t_cmd_in stim, input bit has_want, input t_res_out want);
        t_res_out predicted;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = stim;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = custody_predict(stim);
        expected_results.push_back(has_want ? want : predicted);
        @(negedge i_clk);
    endtask

    // Hold off until every owed result is in and the block has gone quiet
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIME_BITS-1:0] value);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        timeout_reg = value;
    endtask

    // Result side back-pressure in random bursts, off while idling is disabled
    always @(negedge i_clk) begin
        if (!idle_enable) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_res_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            checked_results <= checked_results + 1;
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: st=%0d cust=%h acc=%h dl=%h",
                             $realtime, o_out_data.status, o_out_data.record_custodian,
                             o_out_data.record_accept_time, o_out_data.record_deadline);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.record_custodian !== want.record_custodian ||
                    o_out_data.record_accept_time !== want.record_accept_time ||
                    o_out_data.record_deadline !== want.record_deadline) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp st=%0d cust=%h acc=%h dl=%h, got st=%0d cust=%h acc=%h dl=%h",
                                 $realtime, want.status, want.record_custodian,
                                 want.record_accept_time, want.record_deadline,
                                 o_out_data.status, o_out_data.record_custodian,
                                 o_out_data.record_accept_time, o_out_data.record_deadline);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAIL custody_record_table");
            $finish;
        end
    end

    initial begin
        t_dir_row             directed_rows [N_DIRECTED];
        logic [TIME_BITS-1:0] phase_timeout [N_PHASES];
        int                   phase_items [N_PHASES];
        bit                   phase_fill [N_PHASES];
        t_res_out             no_want;

        no_want = '0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        foreach (custody_tab[i]) custody_tab[i] = '0;
        key_pool[0] = KEY_LO;
        key_pool[1] = KEY_HI;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

        // Directed rows: empty table, refusal reasons, append/update, swap-remove,
        // deadline saturation and the undefined command codes
        directed_rows[0]  = '{mk_cmd(CMD_GET, KEY_LO, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[1]  = '{mk_cmd(CMD_RELEASE, KEY_LO, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[2]  = '{mk_cmd(CMD_TIMEOUT, KEY_LO, 16'h0, T_MAX, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[3]  = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'h5, 32'd0, 1'b1, 32'd10, 32'd10, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, 32'd0, 32'd0)};
        directed_rows[4]  = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'h5, 32'd0, 1'b0, 32'd10, 32'd10, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[5]  = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'h5, 32'd0, 1'b1, 32'd0, 32'd1, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[6]  = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'h5, 32'd0, 1'b1, 32'd10, 32'd0, 1'b1),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[7]  = '{mk_cmd(CMD_ACCEPT, KEY_HI, 16'hFFFF, T_MAX, 1'b1, SZ_MAX, SZ_MAX, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, 32'd0, 32'd0)};
        directed_rows[8]  = '{mk_cmd(CMD_TRANSFER, KEY_LO, 16'hFFFF, 32'd100, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'hFFFF, 32'd100, 32'd3700)};
        directed_rows[9]  = '{mk_cmd(CMD_TRANSFER, KEY_HI, 16'h0, T_MAX, 1'b0, 32'd0, SZ_MAX, 1'b1),
                              1'b1, mk_res(ST_OK, 16'h0, T_MAX, T_MAX)};
        directed_rows[10] = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'hFFFF, 32'd0, 1'b1, 32'd8, 32'd4, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[11] = '{mk_cmd(CMD_ACCEPT, KEY_LO, 16'h1, 32'd0, 1'b1, 32'd8, 32'd4, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, 32'd0, 32'd0)};
        directed_rows[12] = '{mk_cmd(CMD_TRANSFER, KEY_LO, 16'h1, 32'd200, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h1, 32'd200, 32'd3800)};
        directed_rows[13] = '{mk_cmd(CMD_TIMEOUT, KEY_LO, 16'h0, 32'd3799, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h1, 32'd200, 32'd3800)};
        directed_rows[14] = '{mk_cmd(CMD_TIMEOUT, KEY_LO, 16'h0, 32'd3800, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h1, 32'd200, 32'd3800)};
        directed_rows[15] = '{mk_cmd(CMD_GET, KEY_HI, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, T_MAX, T_MAX)};
        directed_rows[16] = '{mk_cmd(CMD_RSVD_FIRST, KEY_LO, 16'h1, 32'd0, 1'b1, 32'd8, 32'd4, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[17] = '{mk_cmd(CMD_RSVD_FIRST + 3'd1, KEY_HI, 16'h0, T_MAX, 1'b1, 32'd0, 32'd0,
                              1'b0), 1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[18] = '{mk_cmd(CMD_RSVD_LAST, KEY_LO, 16'hFFFF, T_MAX, 1'b1, SZ_MAX, 32'd0, 1'b1),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};
        directed_rows[19] = '{mk_cmd(CMD_TRANSFER, KEY_MID, 16'h5A5A, 32'h8000_0000, 1'b1, 32'd0, 32'd0,
                              1'b0), 1'b0, no_want};
        directed_rows[20] = '{mk_cmd(CMD_RELEASE, KEY_LO, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h1, 32'd200, 32'd3800)};
        directed_rows[21] = '{mk_cmd(CMD_GET, KEY_HI, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, T_MAX, T_MAX)};
        directed_rows[22] = '{mk_cmd(CMD_TIMEOUT, KEY_MID, 16'h0, 32'h8000_0000, 1'b1, 32'd0, 32'd0,
                              1'b0), 1'b0, no_want};
        directed_rows[23] = '{mk_cmd(CMD_RELEASE, KEY_HI, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_OK, 16'h0, T_MAX, T_MAX)};
        directed_rows[24] = '{mk_cmd(CMD_GET, KEY_LO, 16'h0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0),
                              1'b1, mk_res(ST_NO, 16'h0, 32'd0, 32'd0)};

        // Random phases: timeout setting, length, and whether the table is driven to full.
        // The last phase runs with no idling on either side.
        phase_timeout = '{32'd0, 32'd1, T_MAX, $urandom, 32'd100};
        phase_items   = '{90, 110, 80, 80, 90};
        phase_fill    = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

        // Synchronous reset, held and then released at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_cmd(directed_rows[i].stim, directed_rows[i].has_want, directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++) begin
            write_timeout(phase_timeout[p]);
            idle_enable = (p != N_PHASES - 1);
            for (int n = 0; n < phase_items[p]; n++)
                send_cmd(next_random_cmd(phase_fill[p]), 1'b0, no_want);
        end
        drain_results();

        $display("ran %0d accept checks, %0d transfers, %0d releases, %0d timeout queries, %0d gets, %0d undefined codes",
                 cmd_seen[CMD_ACCEPT], cmd_seen[CMD_TRANSFER], cmd_seen[CMD_RELEASE],
                 cmd_seen[CMD_TIMEOUT], cmd_seen[CMD_GET],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        $display("table peaked at %0d of %0d records, %0d full refusals, %0d saturated deadlines, %0d results checked, %0d mismatches",
                 peak_fill, CRT_MAX_ENTRIES, full_refusals, saturated_deadlines,
                 checked_results, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS custody_record_table");
        end else begin
            $display("FAIL custody_record_table");
        end
        $finish;
    end

endmodule
